// File: design/cqf_pkg.sv
// Shared types and constants of the circular queue FIFO.
package cqf_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_W    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DELETE  = 2'd1,
    KIND_DISPLAY = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE    = 1'b0,
    BK_DISPLAY = 1'b1
  } bk_state_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

  // command queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q2b_t;

endpackage

// File: design/cqf_front.sv
// Front end: input handshake, kind decode, drop of unused kind codes.
module cqf_front (
  input  logic                                in_valid_i,
  input  logic [cqf_pkg::KIND_W-1:0]          in_kind_i,
  input  logic signed [cqf_pkg::DATA_W-1:0]   in_data_in_i,
  output logic                                in_stall_o,
  input  logic                                q_full_i,
  output logic                                push_o,
  output cqf_pkg::cmd_t                       cmd_o
);

  logic legal;

  assign legal = (in_kind_i == cqf_pkg::KIND_INSERT)  ||
                 (in_kind_i == cqf_pkg::KIND_DELETE)  ||
                 (in_kind_i == cqf_pkg::KIND_DISPLAY);

  assign in_stall_o = q_full_i;
  // unused kind code is accepted and dropped here
  assign push_o     = in_valid_i && !q_full_i && legal;

  always_comb begin
    cmd_o.kind = cqf_pkg::kind_e'(in_kind_i);
    cmd_o.data = in_data_in_i;
  end

endmodule

// File: design/cqf_cmd_queue.sv
// Two-entry command queue between front and back end.
module cqf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cqf_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output cqf_pkg::q2b_t q2b_o
);

  logic [1:0]    cnt_q, cnt_d;
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  cqf_pkg::cmd_t ent_q [2];

  assign full_o       = (cnt_q == 2'd2);
  assign q2b_o.valid  = (cnt_q != 2'd0);
  assign q2b_o.cmd    = ent_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i  ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

endmodule

// File: design/cqf_back.sv
// Back end: slot array, head/tail/occupancy, display walk, output register.
module cqf_back #(
  parameter int unsigned DEPTH = cqf_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cqf_pkg::q2b_t                       q2b_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cqf_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [cqf_pkg::DATA_W-1:0]   out_data_out_o,
  output logic [cqf_pkg::SLOT_W-1:0]          out_slot_o,
  output logic [cqf_pkg::SLOT_W-1:0]          out_front_pos_o,
  output logic [cqf_pkg::SLOT_W-1:0]          out_rear_pos_o,
  output logic                                out_last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SW    = cqf_pkg::SLOT_W;
  localparam int unsigned DW    = cqf_pkg::DATA_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] s);
    return (s == LAST_IDX) ? '0 : s + ONE_IDX;
  endfunction

  cqf_pkg::bk_state_e state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d, walk_q, walk_d;
  logic [CNT_W-1:0]   occ_q, occ_d, rem_q, rem_d;

  logic signed [DW-1:0] slots_q [DEPTH];
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic signed [DW-1:0] rd_data;

  logic                 ovalid_q, ovalid_d;
  cqf_pkg::status_e     status_q, status_d;
  logic signed [DW-1:0] data_q, data_d;
  logic [SW-1:0]        slot_q, slot_d, fpos_q, fpos_d, rpos_q, rpos_d;
  logic                 last_q, last_d;

  logic can_emit;
  logic pop;

  assign can_emit = !ovalid_q || !out_stall_i;
  assign pop      = (state_q == cqf_pkg::BK_IDLE) && q2b_i.valid && can_emit;
  assign pop_o    = pop;

  assign rd_addr = (state_q == cqf_pkg::BK_DISPLAY) ? walk_q : head_q;
  assign rd_data = slots_q[rd_addr];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cqf_pkg::BK_IDLE: begin
        if (pop && q2b_i.cmd.kind == cqf_pkg::KIND_DISPLAY && occ_q > ONE_CNT) begin
          state_d = cqf_pkg::BK_DISPLAY;
        end
      end
      cqf_pkg::BK_DISPLAY: begin
        if (can_emit && rem_q == ONE_CNT) begin
          state_d = cqf_pkg::BK_IDLE;
        end
      end
      default: state_d = cqf_pkg::BK_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    walk_d   = walk_q;
    occ_d    = occ_q;
    rem_d    = rem_q;
    wr_en    = 1'b0;
    wr_addr  = tail_q;
    ovalid_d = ovalid_q && out_stall_i;
    status_d = status_q;
    data_d   = data_q;
    slot_d   = slot_q;
    fpos_d   = fpos_q;
    rpos_d   = rpos_q;
    last_d   = last_q;

    if (pop) begin
      ovalid_d = 1'b1;
      status_d = cqf_pkg::STATUS_OK;
      data_d   = '0;
      slot_d   = '0;
      fpos_d   = SW'(head_q);
      rpos_d   = SW'(tail_q);
      last_d   = 1'b1;
      unique case (q2b_i.cmd.kind)
        cqf_pkg::KIND_INSERT: begin
          if (occ_q == FULL_CNT) begin
            status_d = cqf_pkg::STATUS_OVERFLOW;
          end else begin
            if (occ_q == '0) begin
              head_d = '0;
              tail_d = '0;
            end else begin
              tail_d = next_idx(tail_q);
            end
            occ_d   = occ_q + ONE_CNT;
            wr_en   = 1'b1;
            wr_addr = tail_d;
            data_d  = q2b_i.cmd.data;
            slot_d  = SW'(tail_d);
            fpos_d  = SW'(head_d);
            rpos_d  = SW'(tail_d);
          end
        end
        cqf_pkg::KIND_DELETE: begin
          if (occ_q == '0) begin
            status_d = cqf_pkg::STATUS_UNDERFLOW;
          end else begin
            occ_d = occ_q - ONE_CNT;
            if (occ_q == ONE_CNT) begin
              head_d = '0;
              tail_d = '0;
            end else begin
              head_d = next_idx(head_q);
            end
            data_d = rd_data;
            slot_d = SW'(head_q);
            fpos_d = SW'(head_d);
            rpos_d = SW'(tail_d);
          end
        end
        cqf_pkg::KIND_DISPLAY: begin
          if (occ_q == '0) begin
            status_d = cqf_pkg::STATUS_EMPTY;
          end else begin
            data_d = rd_data;
            slot_d = SW'(head_q);
            last_d = (occ_q == ONE_CNT);
            walk_d = next_idx(head_q);
            rem_d  = occ_q - ONE_CNT;
          end
        end
        default: ovalid_d = ovalid_q && out_stall_i;
      endcase
    end else if (state_q == cqf_pkg::BK_DISPLAY && can_emit) begin
      ovalid_d = 1'b1;
      status_d = cqf_pkg::STATUS_OK;
      data_d   = rd_data;
      slot_d   = SW'(walk_q);
      fpos_d   = SW'(head_q);
      rpos_d   = SW'(tail_q);
      last_d   = (rem_q == ONE_CNT);
      walk_d   = next_idx(walk_q);
      rem_d    = rem_q - ONE_CNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cqf_pkg::BK_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      walk_q   <= '0;
      occ_q    <= '0;
      rem_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      walk_q   <= walk_d;
      occ_q    <= occ_d;
      rem_q    <= rem_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    slot_q   <= slot_d;
    fpos_q   <= fpos_d;
    rpos_q   <= rpos_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_addr] <= q2b_i.cmd.data;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign out_status_o    = status_q;
  assign out_data_out_o  = data_q;
  assign out_slot_o      = slot_q;
  assign out_front_pos_o = fpos_q;
  assign out_rear_pos_o  = rpos_q;
  assign out_last_o      = last_q;

endmodule

// File: design/circular_queue_fifo.sv
// Top level of the circular queue FIFO: front end, command queue, back end.
//
// Fixed-depth circular FIFO of signed 32-bit words driven by insert, delete
// and display items on a valid/stall input channel; results leave on a
// valid/stall output channel through a result register. Insert and delete
// sustain one item per cycle while the output does not stall: the item is
// registered in the two-entry command queue, then the back end executes it
// and registers the result. A display of a non-empty queue holds the back
// end while it reads out every stored word, one read of the slot array per
// cycle unless the output stalls; the command queue absorbs up to two items
// meanwhile and then stalls the input. An output stall holds the back end
// but not the front end until the queue fills. Kind code 3 is accepted and
// dropped without a result. The slot array has no reset; only occupied
// slots are ever read. DEPTH ranges from 2 to 8, as slot numbers are
// reported in 3 bits.
module circular_queue_fifo #(
  parameter int unsigned DEPTH = cqf_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cqf_pkg::KIND_W-1:0]          in_kind_i,
  input  logic signed [cqf_pkg::DATA_W-1:0]   in_data_in_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cqf_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [cqf_pkg::DATA_W-1:0]   out_data_out_o,
  output logic [cqf_pkg::SLOT_W-1:0]          out_slot_o,
  output logic [cqf_pkg::SLOT_W-1:0]          out_front_pos_o,
  output logic [cqf_pkg::SLOT_W-1:0]          out_rear_pos_o,
  output logic                                out_last_o
);

  logic          q_full;
  logic          push;
  logic          pop;
  cqf_pkg::cmd_t cmd;
  cqf_pkg::q2b_t q2b;

  // decode and accept
  cqf_front u_front (
    .in_valid_i   (in_valid_i),
    .in_kind_i    (in_kind_i),
    .in_data_in_i (in_data_in_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  // decouples the input side from display walks and output stalls
  cqf_cmd_queue u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .full_o (q_full),
    .q2b_o  (q2b)
  );

  // storage, pointers and result register
  cqf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q2b_i           (q2b),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_status_o    (out_status_o),
    .out_data_out_o  (out_data_out_o),
    .out_slot_o      (out_slot_o),
    .out_front_pos_o (out_front_pos_o),
    .out_rear_pos_o  (out_rear_pos_o),
    .out_last_o      (out_last_o)
  );

  // back end never takes a command the queue does not hold
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q2b.valid)
    else $error("command popped from empty queue");

  // error and empty results carry no word and end their item
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != cqf_pkg::STATUS_OK) |->
      (out_last_o && out_slot_o == '0 && out_data_out_o == '0))
    else $error("error result with payload or without last");

  // an empty queue always has both positions at slot 0
  a_empty_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == cqf_pkg::STATUS_UNDERFLOW ||
                     out_status_o == cqf_pkg::STATUS_EMPTY)) |->
      (out_front_pos_o == '0 && out_rear_pos_o == '0))
    else $error("empty queue with nonzero front or rear");

  // a full queue keeps stalling the input until the back end pops a command
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !pop) |=> in_stall_o)
    else $error("queue space appeared without a pop");

endmodule

// File: test/tb.sv
// Testbench for circular_queue_fifo: directed and random items checked against a scoreboard.
module tb;

  localparam int unsigned                DEPTH       = cqf_pkg::DEPTH_DEF;
  // kind code with no operation behind it; the block drops it
  localparam logic [cqf_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned                IDLE_PCT    = 22;
  localparam int unsigned                RAND_ITEMS  = 225;
  localparam int unsigned                MAX_REPORTS = 10;

  typedef struct packed {
    cqf_pkg::status_e                  status;
    logic signed [cqf_pkg::DATA_W-1:0] data;
    logic [cqf_pkg::SLOT_W-1:0]        slot;
    logic [cqf_pkg::SLOT_W-1:0]        front;
    logic [cqf_pkg::SLOT_W-1:0]        rear;
    logic                              last;
  } result_t;

  // Scoreboard: mirrors the queue contents and positions, holds expected results.
  class cqf_scoreboard;
    logic signed [cqf_pkg::DATA_W-1:0] words [DEPTH];
    logic [cqf_pkg::SLOT_W-1:0]        head_slot;
    logic [cqf_pkg::SLOT_W-1:0]        tail_slot;
    int unsigned                       fill;
    result_t                           expected_q[$];
    int unsigned                       errors;

    function new();
      head_slot = '0;
      tail_slot = '0;
      fill      = 0;
      errors    = 0;
    endfunction

    function logic [cqf_pkg::SLOT_W-1:0] next_slot(logic [cqf_pkg::SLOT_W-1:0] s);
      return (int'(s) + 1 >= DEPTH) ? '0 : s + cqf_pkg::SLOT_W'(1);
    endfunction

    // positions are reported as they stand after the operation
    function void add_result(cqf_pkg::status_e st, logic signed [cqf_pkg::DATA_W-1:0] d,
                             logic [cqf_pkg::SLOT_W-1:0] s, logic lst);
      result_t r;
      r.status = st;
      r.data   = d;
      r.slot   = s;
      r.front  = head_slot;
      r.rear   = tail_slot;
      r.last   = lst;
      expected_q.push_back(r);
    endfunction

    function void report(string what, result_t want, result_t got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%s: expected st=%0d data=%0d slot=%0d front=%0d rear=%0d last=%0d",
                 what, want.status, want.data, want.slot, want.front, want.rear,
                 want.last);
        $display("%s: got      st=%0d data=%0d slot=%0d front=%0d rear=%0d last=%0d",
                 what, got.status, got.data, got.slot, got.front, got.rear,
                 got.last);
      end
    endfunction

    function void note_item(logic [cqf_pkg::KIND_W-1:0] k,
                            logic signed [cqf_pkg::DATA_W-1:0] d);
      logic [cqf_pkg::SLOT_W-1:0] s;
      case (k)
        cqf_pkg::KIND_INSERT: begin
          if (fill >= DEPTH) begin
            add_result(cqf_pkg::STATUS_OVERFLOW, '0, '0, 1'b1);
          end else begin
            if (fill == 0) begin
              head_slot = '0;
              tail_slot = '0;
            end else begin
              tail_slot = next_slot(tail_slot);
            end
            words[tail_slot] = d;
            fill++;
            add_result(cqf_pkg::STATUS_OK, d, tail_slot, 1'b1);
          end
        end
        cqf_pkg::KIND_DELETE: begin
          if (fill == 0) begin
            add_result(cqf_pkg::STATUS_UNDERFLOW, '0, '0, 1'b1);
          end else begin
            s = head_slot;
            fill--;
            // emptied queue snaps both positions back to slot 0
            if (fill == 0) begin
              head_slot = '0;
              tail_slot = '0;
            end else begin
              head_slot = next_slot(head_slot);
            end
            add_result(cqf_pkg::STATUS_OK, words[s], s, 1'b1);
          end
        end
        cqf_pkg::KIND_DISPLAY: begin
          if (fill == 0) begin
            add_result(cqf_pkg::STATUS_EMPTY, '0, '0, 1'b1);
          end else begin
            s = head_slot;
            for (int i = 0; i < int'(fill); i++) begin
              add_result(cqf_pkg::STATUS_OK, words[s], s, (i + 1 == int'(fill)));
              s = next_slot(s);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        want = '0;
        report("unexpected result", want, got);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status || got.data !== want.data ||
            got.slot !== want.slot || got.front !== want.front ||
            got.rear !== want.rear || got.last !== want.last)
          report("mismatch", want, got);
      end
    endfunction

    function void close_out();
      result_t none;
      none = '0;
      while (expected_q.size() != 0)
        report("missing result", expected_q.pop_front(), none);
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni       = 1'b0;
  logic                              in_valid_i   = 1'b0;
  logic                              in_stall_o;
  logic [cqf_pkg::KIND_W-1:0]        in_kind_i    = '0;
  logic signed [cqf_pkg::DATA_W-1:0] in_data_in_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i  = 1'b0;
  logic [cqf_pkg::STATUS_W-1:0]      out_status_o;
  logic signed [cqf_pkg::DATA_W-1:0] out_data_out_o;
  logic [cqf_pkg::SLOT_W-1:0]        out_slot_o;
  logic [cqf_pkg::SLOT_W-1:0]        out_front_pos_o;
  logic [cqf_pkg::SLOT_W-1:0]        out_rear_pos_o;
  logic                              out_last_o;

  cqf_scoreboard board;
  int unsigned   items_sent = 0;

  circular_queue_fifo #(.DEPTH(DEPTH)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_kind_i      (in_kind_i),
    .in_data_in_i   (in_data_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_status_o   (out_status_o),
    .out_data_out_o (out_data_out_o),
    .out_slot_o     (out_slot_o),
    .out_front_pos_o(out_front_pos_o),
    .out_rear_pos_o (out_rear_pos_o),
    .out_last_o     (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offer one item and hold it until the block takes it. Valid stays high
  // between back-to-back items; items 50..109 go out with no gaps so the
  // long output hold backs the block up.
  task automatic send_item(logic [cqf_pkg::KIND_W-1:0] k,
                           logic signed [cqf_pkg::DATA_W-1:0] d);
    while (!(items_sent >= 50 && items_sent < 110) &&
           $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_kind_i    <= k;
    in_data_in_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(k, d);
    items_sent++;
  endtask

  function automatic logic signed [cqf_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // filling phases push toward full, draining phases toward empty
  function automatic logic [cqf_pkg::KIND_W-1:0] pick_kind(bit filling);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)  return KIND_UNUSED;
    if (r < 20) return cqf_pkg::KIND_DISPLAY;
    if (r < 60) return filling ? cqf_pkg::KIND_INSERT : cqf_pkg::KIND_DELETE;
    if (r < 80) return filling ? cqf_pkg::KIND_DELETE : cqf_pkg::KIND_INSERT;
    return filling ? cqf_pkg::KIND_INSERT : cqf_pkg::KIND_DELETE;
  endfunction

  // Result side: check what is taken, then pick the stall for the next edge.
  initial begin : result_sink
    result_t     got;
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.status = cqf_pkg::status_e'(out_status_o);
        got.data   = out_data_out_o;
        got.slot   = out_slot_o;
        got.front  = out_front_pos_o;
        got.rear   = out_rear_pos_o;
        got.last   = out_last_o;
        board.check_result(got);
      end
      // one long hold while the sender keeps offering
      if (!held && items_sent >= 60) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (items_sent >= 150 && items_sent < 200) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    bit          filling;
    int unsigned waited;
    filling = 1'b1;
    board   = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue: display, underflow, dropped kind
    send_item(cqf_pkg::KIND_DISPLAY, '0);
    send_item(cqf_pkg::KIND_DELETE, '0);
    send_item(KIND_UNUSED, 32'h1234_5678);
    // fill to the brim with field extremes, then overflow
    send_item(cqf_pkg::KIND_INSERT, 32'h8000_0000);
    send_item(cqf_pkg::KIND_INSERT, 32'h7fff_ffff);
    send_item(cqf_pkg::KIND_INSERT, '0);
    send_item(cqf_pkg::KIND_INSERT, '1);
    send_item(cqf_pkg::KIND_INSERT, 32'h5555_5555);
    send_item(cqf_pkg::KIND_INSERT, 32'haaaa_aaaa);
    send_item(cqf_pkg::KIND_INSERT, 32'h0000_0001);
    send_item(cqf_pkg::KIND_INSERT, pick_word());
    send_item(cqf_pkg::KIND_INSERT, '1);
    send_item(cqf_pkg::KIND_DISPLAY, '0);
    // wrap the tail around the end of storage
    send_item(cqf_pkg::KIND_DELETE, '0);
    send_item(cqf_pkg::KIND_DELETE, '0);
    send_item(cqf_pkg::KIND_INSERT, 32'hdead_beef);
    send_item(cqf_pkg::KIND_INSERT, 32'h0bad_f00d);
    send_item(cqf_pkg::KIND_DISPLAY, '0);
    // drain fully; the last delete resets both positions
    repeat (DEPTH) send_item(cqf_pkg::KIND_DELETE, '0);

    for (int n = 0; n < int'(RAND_ITEMS); n++) begin
      if (n % 20 == 0) filling = 1'($urandom_range(1));
      send_item(pick_kind(filling), pick_word());
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (board.expected_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (12) @(posedge clk_i);
    board.close_out();
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2400000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
